// File: src/case_insensitive_last_match_search_macros.svh
// assertion macros shared by the search block
`ifndef CASE_INSENSITIVE_LAST_MATCH_SEARCH_MACROS_SVH
`define CASE_INSENSITIVE_LAST_MATCH_SEARCH_MACROS_SVH

// checked on every clock, skipped while reset is high
`define CLMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// checked on every clock, including reset cycles
`define CLMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: src/clms_pkg.sv
// types, constants and helpers for the case-insensitive last match search
package clms_pkg;

  localparam int CLMS_MAX_NEEDLE = 8;
  localparam int CLMS_POS_BITS   = 16;
  localparam int CHAR_W          = 8;
  localparam int LEN_W           = 4;
  localparam int NEEDLE_W        = 64;
  localparam int NEEDLE_BYTES    = NEEDLE_W / CHAR_W;
  localparam int NB_IDX_W        = $clog2(NEEDLE_BYTES);
  localparam int START_W         = 16;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 64;

  typedef logic [CHAR_W-1:0] char_t;

  localparam char_t CHAR_UPPER_A = 8'h41;
  localparam char_t CHAR_UPPER_Z = 8'h5A;
  localparam char_t CASE_OFFSET  = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEEDLE_LEN   = 1'b0,
    CFG_NEEDLE_CHARS = 1'b1
  } cfg_reg_t;

  // folded byte waiting in the input register
  typedef struct packed {
    logic  valid;
    char_t ch;
    logic  last;
  } stage_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] match_start;
    logic               overflow;
  } result_t;

  // ascii upper case to lower case, other bytes untouched
  function automatic char_t fold_char(input char_t c);
    char_t r;
    r = c;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// File: src/clms_hay_if.sv
// haystack byte channel
interface clms_hay_if;
  import clms_pkg::*;

  logic  valid;
  logic  ready;
  char_t hay_char;
  logic  is_last;

  modport source (output valid, hay_char, is_last, input ready);
  modport sink (input valid, hay_char, is_last, output ready);
endinterface

// File: src/clms_res_if.sv
// search result channel
interface clms_res_if;
  import clms_pkg::*;

  logic               valid;
  logic               ready;
  logic               found;
  logic [START_W-1:0] match_start;
  logic               overflow;

  modport source (output valid, found, match_start, overflow, input ready);
  modport sink (input valid, found, match_start, overflow, output ready);
endinterface

// File: src/clms_in_stage.sv
// input register: takes a haystack byte and holds it case-folded
module clms_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  clms_pkg::char_t in_char,
  input  logic            in_last,
  input  logic            adv,
  output logic            in_ready,
  output clms_pkg::stage_t stage
);
  import clms_pkg::*;

  logic  stage_valid;
  char_t stage_ch;
  logic  stage_last;

  assign in_ready = !stage_valid || adv;
  assign stage    = '{valid: stage_valid, ch: stage_ch, last: stage_last};

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_ch   <= fold_char(in_char);
      stage_last <= in_last;
    end
  end
endmodule

// File: src/clms_match.sv
// window, position counter and needle compare for one byte per clock while adv is high
module clms_match #(
  parameter int MAX_NEEDLE = clms_pkg::CLMS_MAX_NEEDLE,
  parameter int POS_BITS   = clms_pkg::CLMS_POS_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  clms_pkg::stage_t                stage,
  input  logic                            adv,
  input  logic [clms_pkg::LEN_W-1:0]      needle_len,
  input  logic [clms_pkg::NEEDLE_W-1:0]   needle_chars,
  output clms_pkg::result_t               result
);
  import clms_pkg::*;

  char_t               window [MAX_NEEDLE];
  char_t               win_next [MAX_NEEDLE];
  char_t               needle_bytes [NEEDLE_BYTES];
  logic [POS_BITS-1:0] position;
  logic                pos_full;
  logic [POS_BITS-1:0] last_start;
  logic                seen_match;
  logic                pos_overflow;

  logic [POS_BITS-1:0]         idx;
  logic [LEN_W-1:0]            len_m1;
  logic [POS_BITS-1:0]         len_m1_ext;
  logic                        len_ok;
  logic                        count_ok;
  logic [MAX_NEEDLE-1:0]       hit;
  logic                        match_now;
  logic [POS_BITS-1:0]         start_now;
  logic [POS_BITS-1:0]         start_sel;
  logic [POS_BITS+START_W-1:0] start_wide;

  // saturated index of the byte in the input register
  assign idx        = pos_full ? '1 : position;
  assign len_m1     = needle_len - LEN_W'(1);
  assign len_m1_ext = {{(POS_BITS-LEN_W){1'b0}}, len_m1};
  assign len_ok     = (needle_len != '0) && (needle_len <= LEN_W'(MAX_NEEDLE));
  assign count_ok   = idx >= len_m1_ext;

  always_comb begin
    for (int b = 0; b < NEEDLE_BYTES; b++) begin
      needle_bytes[b] = needle_chars[b*CHAR_W +: CHAR_W];
    end
  end

  always_comb begin
    win_next[0] = stage.ch;
    for (int i = 1; i < MAX_NEEDLE; i++) begin
      win_next[i] = window[i-1];
    end
  end

  // window slot i holds the needle byte len-1-i when the tail matches
  always_comb begin
    logic [LEN_W-1:0] k;
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      k      = len_m1 - LEN_W'(i);
      hit[i] = (LEN_W'(i) >= needle_len) ||
               (win_next[i] == fold_char(needle_bytes[k[NB_IDX_W-1:0]]));
    end
  end

  assign match_now  = len_ok && count_ok && (&hit);
  assign start_now  = idx - len_m1_ext;
  assign start_sel  = match_now ? start_now : last_start;
  assign start_wide = {{START_W{1'b0}}, start_sel};

  always_comb begin
    result.found       = seen_match || match_now;
    result.match_start = result.found ? start_wide[START_W-1:0] : '0;
    result.overflow    = pos_overflow || pos_full;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      window <= win_next;
      if (match_now) begin
        last_start <= start_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (adv && stage.last)) begin
      position     <= '0;
      pos_full     <= 1'b0;
      seen_match   <= 1'b0;
      pos_overflow <= 1'b0;
    end else if (adv) begin
      if (match_now) begin
        seen_match <= 1'b1;
      end
      if (pos_full) begin
        pos_overflow <= 1'b1;
      end else if (position == '1) begin
        pos_full <= 1'b1;
      end else begin
        position <= position + POS_BITS'(1);
      end
    end
  end
endmodule

// File: src/case_insensitive_last_match_search.sv
// top level of the case-insensitive last match search
// Streams a haystack one byte per request and reports the rightmost
// case-insensitive occurrence of a needle of up to MAX_NEEDLE bytes. Program
// needle_len (index 0) and needle_chars (index 1, first character in the low
// byte) while no haystack is in flight. Every haystack byte is folded to lower
// case in the input register; there the window shift, needle compare and
// position update happen together, so one byte is taken every clock unless
// a last byte is held back; the result register loads as it moves on. The
// window/compare/counter update loop is what sets that rate. The last byte
// of a haystack waits in the input register only while the result register
// is still full. An empty needle, a length above MAX_NEEDLE or a haystack
// shorter than the needle reports not found; overflow marks a haystack longer
// than 2^POS_BITS bytes, after which the position sticks at its top value.
`include "case_insensitive_last_match_search_macros.svh"

module case_insensitive_last_match_search #(
  parameter int MAX_NEEDLE = clms_pkg::CLMS_MAX_NEEDLE,
  parameter int POS_BITS   = clms_pkg::CLMS_POS_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [clms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [clms_pkg::CFG_DATA_W-1:0]   cfg_data,
  clms_hay_if.sink                          hay,
  clms_res_if.source                        res
);
  import clms_pkg::*;

  // configuration registers
  logic [LEN_W-1:0]    needle_len;
  logic [NEEDLE_W-1:0] needle_chars;

  stage_t  stage;
  result_t result;
  logic    adv;

  // result register
  logic    res_valid;
  result_t res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_len   <= '0;
      needle_chars <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_NEEDLE_LEN:   needle_len   <= cfg_data[LEN_W-1:0];
        CFG_NEEDLE_CHARS: needle_chars <= cfg_data[NEEDLE_W-1:0];
        default:          ;
      endcase
    end
  end

  // a byte moves on unless it ends a haystack and the result slot is busy
  assign adv = stage.valid && (!stage.last || !res_valid || res.ready);

  clms_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (hay.valid),
    .in_char  (hay.hay_char),
    .in_last  (hay.is_last),
    .adv      (adv),
    .in_ready (hay.ready),
    .stage    (stage)
  );

  clms_match #(
    .MAX_NEEDLE (MAX_NEEDLE),
    .POS_BITS   (POS_BITS)
  ) u_match (
    .clk          (clk),
    .rst          (rst),
    .stage        (stage),
    .adv          (adv),
    .needle_len   (needle_len),
    .needle_chars (needle_chars),
    .result       (result)
  );

  // result slot fills on the last byte and empties when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv && stage.last) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && stage.last) begin
      res_data <= result;
    end
  end

  assign res.valid       = res_valid;
  assign res.found       = res_data.found;
  assign res.match_start = res_data.match_start;
  assign res.overflow    = res_data.overflow;

  `CLMS_ASSERT(a_start_zero_unfound, res.valid && !res.found |-> res.match_start == '0, "match start set without a match")
  `CLMS_ASSERT(a_last_gives_result, adv && stage.last |=> res.valid, "last byte did not load a result")
  `CLMS_ASSERT(a_full_slot_blocks, stage.valid && stage.last && res.valid && !res.ready |-> !hay.ready, "input taken while last byte is stalled")
  `CLMS_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !res.valid && !stage.valid, "pipeline not empty after reset")
endmodule
